[hdl/nzda_pkg.sv]
`default_nettype none

package nzda_pkg;

    // One input word: a sentence character or an end-of-message mark
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
    } in_item_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_NOT_ZDA     = 3'd2,
        ST_FIELD_COUNT = 3'd3,
        ST_DAY         = 3'd4,
        ST_MONTH       = 3'd5,
        ST_YEAR        = 3'd6,
        ST_TIME        = 3'd7
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        date_valid;
        logic        time_valid;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [6:0]  seconds;
        logic [9:0]  milliseconds;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
    } out_item_t;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOM  = 1'b1;

    localparam logic [3:0] FLD_HEADER = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_DAY    = 4'd2;
    localparam logic [3:0] FLD_MONTH  = 4'd3;
    localparam logic [3:0] FLD_YEAR   = 4'd4;
    localparam logic [3:0] FLD_TOTAL  = 4'd8;

    localparam logic [3:0] LEN_SAT        = 4'd15;
    localparam logic [3:0] LEN_HEADER     = 4'd6;
    localparam logic [3:0] LEN_TIME_SHORT = 4'd6;
    localparam logic [3:0] LEN_TIME_LONG  = 4'd10;
    localparam logic [3:0] LEN_DAY        = 4'd2;
    localparam logic [3:0] LEN_MONTH      = 4'd2;
    localparam logic [3:0] LEN_YEAR       = 4'd4;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Expected header text, one character per position
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (idx)
            3'd0:    c = 8'h24;  // $
            3'd1:    c = 8'h47;  // G
            3'd2:    c = 8'h50;  // P
            3'd3:    c = 8'h5A;  // Z
            3'd4:    c = 8'h44;  // D
            3'd5:    c = 8'h41;  // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/nzda_in_stage.sv]
`default_nettype none

module nzda_in_stage
    import nzda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid,
    output logic          ready,
    input  wire in_item_t item,
    input  wire logic     pop,
    output logic          held_valid,
    output in_item_t      held_item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t item_reg;

    // Take a new word when nothing is held or the held one leaves this cycle
    assign ready    = !vld_reg || pop;
    assign vld_next = valid ? 1'b1 : (vld_reg && !pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ready)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = vld_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

[hdl/nzda_parse_core.sv]
`default_nettype none

module nzda_parse_core
    import nzda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     advance,
    input  wire in_item_t item,
    output out_item_t     result
);

    logic [3:0]  fnum_reg, fnum_next;
    logic [3:0]  flen_reg, flen_next;
    logic        saw_reg, saw_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [3:0]  tlen_reg, tlen_next;
    logic [3:0]  dlen_reg, dlen_next;
    logic [3:0]  mlen_reg, mlen_next;
    logic [3:0]  ylen_reg, ylen_next;
    logic [3:0]  bad_reg, bad_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic [9:0]  frac_reg, frac_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  mon_reg, mon_next;
    logic [13:0] year_reg, year_next;

    logic        is_delim;
    logic        is_digit;
    logic [3:0]  dval;
    logic        bad_char;

    // Values as they stand once the last field is closed at end of message
    logic        cl_active;
    logic [3:0]  cl_fnum;
    logic        cl_hdr_ok;
    logic [3:0]  cl_tlen;
    logic [3:0]  cl_dlen;
    logic [3:0]  cl_mlen;
    logic [3:0]  cl_ylen;
    logic        date_ok;
    logic        time_ok;
    status_t     status;

    assign is_delim = (item.ch == CH_COMMA) || (item.ch == CH_STAR);
    assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
    assign dval     = is_digit ? item.ch[3:0] : 4'd0;
    assign bad_char = !is_digit;

    always_comb
    begin
        fnum_next   = fnum_reg;
        flen_next   = flen_reg;
        saw_next    = saw_reg;
        hdr_ok_next = hdr_ok_reg;
        tlen_next   = tlen_reg;
        dlen_next   = dlen_reg;
        mlen_next   = mlen_reg;
        ylen_next   = ylen_reg;
        bad_next    = bad_reg;
        hour_next   = hour_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        frac_next   = frac_reg;
        day_next    = day_reg;
        mon_next    = mon_reg;
        year_next   = year_reg;

        if (advance && item.cmd == CMD_EOM)
        begin
            // Back to the reset state for the next sentence
            fnum_next   = 4'd0;
            flen_next   = 4'd0;
            saw_next    = 1'b0;
            hdr_ok_next = 1'b1;
            tlen_next   = 4'd0;
            dlen_next   = 4'd0;
            mlen_next   = 4'd0;
            ylen_next   = 4'd0;
            bad_next    = 4'd0;
            hour_next   = 7'd0;
            min_next    = 7'd0;
            sec_next    = 7'd0;
            frac_next   = 10'd0;
            day_next    = 7'd0;
            mon_next    = 7'd0;
            year_next   = 14'd0;
        end
        else if (advance)
        begin
            saw_next = 1'b1;
            if (is_delim)
            begin
                // Close the field; empty fields are dropped
                if (flen_reg != 4'd0)
                begin
                    unique case (fnum_reg)
                        FLD_HEADER: if (flen_reg != LEN_HEADER) hdr_ok_next = 1'b0;
                        FLD_TIME:   tlen_next = flen_reg;
                        FLD_DAY:    dlen_next = flen_reg;
                        FLD_MONTH:  mlen_next = flen_reg;
                        FLD_YEAR:   ylen_next = flen_reg;
                        default:    ;
                    endcase
                    if (fnum_reg != LEN_SAT)
                    begin
                        fnum_next = fnum_reg + 4'd1;
                    end
                    flen_next = 4'd0;
                end
            end
            else
            begin
                unique case (fnum_reg)
                    FLD_HEADER:
                    begin
                        if (flen_reg >= LEN_HEADER)
                        begin
                            hdr_ok_next = 1'b0;
                        end
                        else if (item.ch != hdr_char(flen_reg[2:0]))
                        begin
                            hdr_ok_next = 1'b0;
                        end
                    end
                    FLD_TIME:
                    begin
                        if (flen_reg < 4'd2)
                        begin
                            hour_next   = (hour_reg << 3) + (hour_reg << 1) + 7'(dval);
                            bad_next[0] = bad_reg[0] | bad_char;
                        end
                        else if (flen_reg < 4'd4)
                        begin
                            min_next    = (min_reg << 3) + (min_reg << 1) + 7'(dval);
                            bad_next[0] = bad_reg[0] | bad_char;
                        end
                        else if (flen_reg < 4'd6)
                        begin
                            sec_next    = (sec_reg << 3) + (sec_reg << 1) + 7'(dval);
                            bad_next[0] = bad_reg[0] | bad_char;
                        end
                        else if (flen_reg == 4'd6)
                        begin
                            if (item.ch != CH_DOT)
                            begin
                                bad_next[0] = 1'b1;
                            end
                        end
                        else if (flen_reg < LEN_TIME_LONG)
                        begin
                            frac_next   = (frac_reg << 3) + (frac_reg << 1) + 10'(dval);
                            bad_next[0] = bad_reg[0] | bad_char;
                        end
                    end
                    FLD_DAY:
                    begin
                        if (flen_reg < LEN_DAY)
                        begin
                            day_next    = (day_reg << 3) + (day_reg << 1) + 7'(dval);
                            bad_next[1] = bad_reg[1] | bad_char;
                        end
                    end
                    FLD_MONTH:
                    begin
                        if (flen_reg < LEN_MONTH)
                        begin
                            mon_next    = (mon_reg << 3) + (mon_reg << 1) + 7'(dval);
                            bad_next[2] = bad_reg[2] | bad_char;
                        end
                    end
                    FLD_YEAR:
                    begin
                        if (flen_reg < LEN_YEAR)
                        begin
                            year_next   = (year_reg << 3) + (year_reg << 1) + 14'(dval);
                            bad_next[3] = bad_reg[3] | bad_char;
                        end
                    end
                    default: ;
                endcase
                if (flen_reg != LEN_SAT)
                begin
                    flen_next = flen_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fnum_reg   <= 4'd0;
            flen_reg   <= 4'd0;
            saw_reg    <= 1'b0;
            hdr_ok_reg <= 1'b1;
            tlen_reg   <= 4'd0;
            dlen_reg   <= 4'd0;
            mlen_reg   <= 4'd0;
            ylen_reg   <= 4'd0;
            bad_reg    <= 4'd0;
            hour_reg   <= 7'd0;
            min_reg    <= 7'd0;
            sec_reg    <= 7'd0;
            frac_reg   <= 10'd0;
            day_reg    <= 7'd0;
            mon_reg    <= 7'd0;
            year_reg   <= 14'd0;
        end
        else
        begin
            fnum_reg   <= fnum_next;
            flen_reg   <= flen_next;
            saw_reg    <= saw_next;
            hdr_ok_reg <= hdr_ok_next;
            tlen_reg   <= tlen_next;
            dlen_reg   <= dlen_next;
            mlen_reg   <= mlen_next;
            ylen_reg   <= ylen_next;
            bad_reg    <= bad_next;
            hour_reg   <= hour_next;
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            frac_reg   <= frac_next;
            day_reg    <= day_next;
            mon_reg    <= mon_next;
            year_reg   <= year_next;
        end
    end

    // Close the trailing field before judging the sentence
    always_comb
    begin
        cl_active = (flen_reg != 4'd0);
        cl_fnum   = fnum_reg;
        cl_hdr_ok = hdr_ok_reg;
        cl_tlen   = tlen_reg;
        cl_dlen   = dlen_reg;
        cl_mlen   = mlen_reg;
        cl_ylen   = ylen_reg;
        if (cl_active)
        begin
            unique case (fnum_reg)
                FLD_HEADER: if (flen_reg != LEN_HEADER) cl_hdr_ok = 1'b0;
                FLD_TIME:   cl_tlen = flen_reg;
                FLD_DAY:    cl_dlen = flen_reg;
                FLD_MONTH:  cl_mlen = flen_reg;
                FLD_YEAR:   cl_ylen = flen_reg;
                default:    ;
            endcase
            if (fnum_reg != LEN_SAT)
            begin
                cl_fnum = fnum_reg + 4'd1;
            end
        end
    end

    always_comb
    begin
        date_ok = 1'b0;
        time_ok = 1'b0;
        priority if (!saw_reg)
        begin
            status = ST_EMPTY;
        end
        else if (cl_fnum == FLD_HEADER || !cl_hdr_ok)
        begin
            status = ST_NOT_ZDA;
        end
        else if (cl_fnum != FLD_TOTAL)
        begin
            status = ST_FIELD_COUNT;
        end
        else if (cl_dlen != LEN_DAY || bad_reg[1])
        begin
            status = ST_DAY;
        end
        else if (cl_mlen != LEN_MONTH || bad_reg[2])
        begin
            status = ST_MONTH;
        end
        else if (cl_ylen != LEN_YEAR || bad_reg[3])
        begin
            status = ST_YEAR;
        end
        else if ((cl_tlen != LEN_TIME_SHORT && cl_tlen != LEN_TIME_LONG) || bad_reg[0])
        begin
            status  = ST_TIME;
            date_ok = 1'b1;
        end
        else
        begin
            status  = ST_OK;
            date_ok = 1'b1;
            time_ok = 1'b1;
        end
    end

    always_comb
    begin
        result.status       = status;
        result.date_valid   = date_ok;
        result.time_valid   = time_ok;
        result.hours        = time_ok ? hour_reg : 7'd0;
        result.minutes      = time_ok ? min_reg : 7'd0;
        result.seconds      = time_ok ? sec_reg : 7'd0;
        result.milliseconds = (time_ok && cl_tlen == LEN_TIME_LONG) ? frac_reg : 10'd0;
        result.day          = date_ok ? day_reg : 7'd0;
        result.month        = date_ok ? mon_reg : 7'd0;
        result.year         = date_ok ? year_reg : 14'd0;
    end

endmodule

`default_nettype wire

[hdl/nzda_out_stage.sv]
`default_nettype none

module nzda_out_stage
    import nzda_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      load,
    input  wire out_item_t data,
    output logic           free,
    output logic           valid,
    input  wire logic      ready,
    output out_item_t      item
);

    logic      vld_reg;
    logic      vld_next;
    out_item_t data_reg;

    assign free     = !vld_reg || ready;
    assign vld_next = load ? 1'b1 : (vld_reg && !ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign valid = vld_reg;
    assign item  = data_reg;

endmodule

`default_nettype wire

[hdl/nmea_zda_time_parser.sv]
// ZDA sentence parser. Characters of one sentence arrive as words with cmd low, and a
// word with cmd high closes the sentence and yields one result word with the status and the
// decoded date and time; character words yield nothing. Every word passes through an input
// register and is folded into the field state in the following cycle, unless it is an
// end-of-message word that waits for room in the result register; so one word is taken per
// clock while no such word waits. Only a result word held back by result_ready stalls the
// input, and then only once an end-of-message word is waiting behind it.
`default_nettype none

module nmea_zda_time_parser
    import nzda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire in_item_t item,
    output logic          result_valid,
    input  wire logic     result_ready,
    output out_item_t     result
);

    logic      held_valid;
    in_item_t  held_item;
    logic      out_free;
    logic      advance;
    logic      load_result;
    out_item_t core_result;

    // Characters never wait; end of message waits for room in the result register
    assign advance     = held_valid && (held_item.cmd == CMD_CHAR || out_free);
    assign load_result = advance && held_item.cmd == CMD_EOM;

    nzda_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (item_valid),
        .ready      (item_ready),
        .item       (item),
        .pop        (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    nzda_parse_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (core_result)
    );

    nzda_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_result),
        .data  (core_result),
        .free  (out_free),
        .valid (result_valid),
        .ready (result_ready),
        .item  (result)
    );

    a_time_needs_date: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.time_valid || result.date_valid))
        else $error("time valid without date valid");

    a_ok_matches_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.time_valid == (result.status == ST_OK)))
        else $error("time valid disagrees with status");

    a_date_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            (result.date_valid == (result.status == ST_OK || result.status == ST_TIME)))
        else $error("date valid disagrees with status");

    a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held_item.cmd == CMD_CHAR && !(result_valid && !result_ready))
            |=> !result_valid)
        else $error("result produced by a character word");

endmodule

`default_nettype wire

[tb/nmea_zda_time_parser_tb.sv]
module nmea_zda_time_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nzda_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RAND_WORDS   = 925;
    localparam int RAND_RESULTS = 25;
    localparam int LONG_HOLD    = 1500;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_NS     = 5_000_000;

    localparam int BAD_TIME  = 0;
    localparam int BAD_DAY   = 1;
    localparam int BAD_MONTH = 2;
    localparam int BAD_YEAR  = 3;

    localparam logic [3:0]   IDX_SAT = 4'd15;
    localparam logic [47:0]  ZDA_TAG = "$GPZDA";
    localparam logic [127:0] HEX_SET = "0123456789ABCDEF";
    localparam out_item_t    NO_WANT = '0;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    nmea_zda_time_parser uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Sentence decoder state
    logic [3:0]  fld_idx, fld_len, t_len, d_len, m_len, y_len, bad_marks;
    logic        any_char, hdr_ok;
    logic [6:0]  hh, mi, ss, dd, mo;
    logic [9:0]  frac;
    logic [13:0] yy;

    out_item_t   zda_due[$];
    logic [7:0]  sentence[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          eoms_sent  = 0;
    bit          burst      = 1'b0;
    bit          hold_due   = 1'b0;

    // Directed sentences; an end-of-message word follows each one
    localparam int NDIR = 24;

    string dir_text [NDIR] = '{
        "",
        ",,**,",
        "$GPZDA,000000,00,00,0000,00,00*00",
        "$GPZDA,999999.999,99,99,9999,99,99*FF",
        "$GPZDA,201530.00,04,07,2002,00,00*60",
        "$GPZDA,201530.123,04,07,2002,00,00*60",
        ",$GPZDA,,,082406,,15,**11,,2024,-05,30*4A,,",
        "$GPZDB,201530,04,07,2002,00,00*60",
        "$GPZDAX,201530,04,07,2002,00,00*60",
        "$GPZD,201530,04,07,2002,00,00*60",
        "$GPZDA,201530,04,07,2002,00*60",
        "$GPZDA,201530,04,07,2002,00,00,01*60",
        "$GPZDA,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17",
        "$GPZDA,201530,041,07,2002,00,00*60",
        "$GPZDA,201530,0a,07,2002,00,00*60",
        "$GPZDA,201530,04,7,2002,00,00*60",
        "$GPZDA,201530,04,/7,2002,00,00*60",
        "$GPZDA,201530,04,07,20:2,00,00*60",
        "$GPZDA,201530,04,07,20021234567890123,00,00*60",
        "$GPZDA,201530x123,04,07,2002,00,00*60",
        "$GPZDA,2015a0,04,07,2002,00,00*60",
        "$GPZDA,201530.1234567890,04,07,2002,00,00*60",
        "$GPZDA,235959.500,31,12,1999,\377\200,00*7F",
        "$GPZDA,123456,01,01,2000,00,00,5C"
    };

    bit dir_typed [NDIR] = '{
        1, 1, 1, 1, 1, 0, 0, 1, 1, 1, 1, 1,
        1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0
    };

    out_item_t dir_want [NDIR] = '{
        '{ST_EMPTY,       1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_NOT_ZDA,     1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_OK,          1'b1, 1'b1, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_OK,          1'b1, 1'b1, 7'd99, 7'd99, 7'd99, 10'd999, 7'd99, 7'd99, 14'd9999},
        '{ST_TIME,        1'b1, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd4,  7'd7,  14'd2002},
        NO_WANT,
        NO_WANT,
        '{ST_NOT_ZDA,     1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_NOT_ZDA,     1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_NOT_ZDA,     1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_FIELD_COUNT, 1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_FIELD_COUNT, 1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_FIELD_COUNT, 1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_DAY,         1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_DAY,         1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_MONTH,       1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_MONTH,       1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_YEAR,        1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_YEAR,        1'b0, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd0,  7'd0,  14'd0},
        '{ST_TIME,        1'b1, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd4,  7'd7,  14'd2002},
        '{ST_TIME,        1'b1, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd4,  7'd7,  14'd2002},
        '{ST_TIME,        1'b1, 1'b0, 7'd0,  7'd0,  7'd0,  10'd0,   7'd4,  7'd7,  14'd2002},
        NO_WANT,
        NO_WANT
    };

    function automatic void clear_sentence();
        fld_idx   = '0;
        fld_len   = '0;
        any_char  = 1'b0;
        hdr_ok    = 1'b1;
        t_len     = '0;
        d_len     = '0;
        m_len     = '0;
        y_len     = '0;
        bad_marks = '0;
        hh        = '0;
        mi        = '0;
        ss        = '0;
        frac      = '0;
        dd        = '0;
        mo        = '0;
        yy        = '0;
    endfunction

    function automatic logic [3:0] digit_in(input logic [7:0] c, input int mark);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 4'(c - CH_ZERO);
        bad_marks[mark] = 1'b1;
        return 4'd0;
    endfunction

    function automatic void close_field();
        if (fld_len == 0)
            return;
        case (fld_idx)
            FLD_HEADER: if (fld_len != LEN_HEADER) hdr_ok = 1'b0;
            FLD_TIME:   t_len = fld_len;
            FLD_DAY:    d_len = fld_len;
            FLD_MONTH:  m_len = fld_len;
            FLD_YEAR:   y_len = fld_len;
            default:    ;
        endcase
        if (fld_idx != IDX_SAT)
            fld_idx = fld_idx + 4'd1;
        fld_len = '0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        logic [3:0] p;
        p = fld_len;
        case (fld_idx)
            FLD_HEADER:
            begin
                if (p >= LEN_HEADER)
                    hdr_ok = 1'b0;
                else if (c != ZDA_TAG[(5 - p) * 8 +: 8])
                    hdr_ok = 1'b0;
            end
            FLD_TIME:
            begin
                if (p < 2)
                    hh = 7'(hh * 10 + digit_in(c, BAD_TIME));
                else if (p < 4)
                    mi = 7'(mi * 10 + digit_in(c, BAD_TIME));
                else if (p < 6)
                    ss = 7'(ss * 10 + digit_in(c, BAD_TIME));
                else if (p == 6)
                begin
                    if (c != CH_DOT)
                        bad_marks[BAD_TIME] = 1'b1;
                end
                else if (p < 10)
                    frac = 10'(frac * 10 + digit_in(c, BAD_TIME));
            end
            FLD_DAY:   if (p < 2) dd = 7'(dd * 10 + digit_in(c, BAD_DAY));
            FLD_MONTH: if (p < 2) mo = 7'(mo * 10 + digit_in(c, BAD_MONTH));
            FLD_YEAR:  if (p < 4) yy = 14'(yy * 10 + digit_in(c, BAD_YEAR));
            default:   ;
        endcase
        if (fld_len != IDX_SAT)
            fld_len = fld_len + 4'd1;
    endfunction

    // Fold one word into the decoder; returns 1 with the decoded result when it closes a sentence
    function automatic bit fold_word(input in_item_t w, output out_item_t r);
        bit      date_ok;
        bit      time_ok;
        status_t st;
        r = '0;
        if (w.cmd == CMD_CHAR)
        begin
            any_char = 1'b1;
            if (w.ch == CH_COMMA || w.ch == CH_STAR)
                close_field();
            else
                take_char(w.ch);
            return 1'b0;
        end
        close_field();
        date_ok = 1'b0;
        time_ok = 1'b0;
        if (!any_char)
            st = ST_EMPTY;
        else if (fld_idx == FLD_HEADER || !hdr_ok)
            st = ST_NOT_ZDA;
        else if (fld_idx != FLD_TOTAL)
            st = ST_FIELD_COUNT;
        else if (d_len != LEN_DAY || bad_marks[BAD_DAY])
            st = ST_DAY;
        else if (m_len != LEN_MONTH || bad_marks[BAD_MONTH])
            st = ST_MONTH;
        else if (y_len != LEN_YEAR || bad_marks[BAD_YEAR])
            st = ST_YEAR;
        else
        begin
            date_ok = 1'b1;
            if ((t_len != LEN_TIME_SHORT && t_len != LEN_TIME_LONG) || bad_marks[BAD_TIME])
                st = ST_TIME;
            else
            begin
                st      = ST_OK;
                time_ok = 1'b1;
            end
        end
        r.status       = st;
        r.date_valid   = date_ok;
        r.time_valid   = time_ok;
        r.hours        = time_ok ? hh : '0;
        r.minutes      = time_ok ? mi : '0;
        r.seconds      = time_ok ? ss : '0;
        r.milliseconds = (time_ok && t_len == LEN_TIME_LONG) ? frac : '0;
        r.day          = date_ok ? dd : '0;
        r.month        = date_ok ? mo : '0;
        r.year         = date_ok ? yy : '0;
        clear_sentence();
        return 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Append one character to the sentence under construction
    task automatic append_char(input logic [7:0] c);
        sentence.insert(sentence.size(), c);
    endtask

    task automatic send_word(input in_item_t w, input bit typed, input out_item_t want);
        int        gap;
        out_item_t got;
        gap = burst ? 0 : idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_sent++;
        if (fold_word(w, got))
        begin
            eoms_sent++;
            zda_due.insert(zda_due.size(), typed ? want : got);
        end
    endtask

    task automatic send_sentence(input bit typed, input out_item_t want);
        burst = ($urandom_range(0, 3) == 0);
        foreach (sentence[i])
            send_word('{cmd: CMD_CHAR, ch: sentence[i]}, 1'b0, NO_WANT);
        // ch is ignored on the closing word, so let it wander
        send_word('{cmd: CMD_EOM, ch: 8'($urandom_range(0, 255))}, typed, want);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n)
            append_char(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic add_sep();
        append_char(CH_COMMA);
        if ($urandom_range(0, 9) == 0)
            append_char(($urandom_range(0, 1) == 0) ? CH_COMMA : CH_STAR);
    endtask

    // Malformed field: any length up to past saturation, mostly digits
    task automatic add_junk();
        int n;
        int r;
        n = $urandom_range(0, 17);
        repeat (n)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                add_digits(1);
            else if (r < 7)
                append_char(CH_DOT);
            else
                append_char(8'($urandom_range(32, 126)));
        end
    endtask

    task automatic build_sentence();
        int kind;
        int n;
        sentence.delete();
        kind = $urandom_range(0, 99);
        if (kind < 4)
            return;
        if (kind < 18)
        begin
            n = $urandom_range(1, 40);
            repeat (n)
            begin
                if ($urandom_range(0, 3) == 0)
                    append_char(($urandom_range(0, 1) == 0) ? CH_COMMA : CH_STAR);
                else
                    append_char(8'($urandom_range(0, 255)));
            end
            return;
        end
        load_text("$GPZDA");
        if ($urandom_range(0, 19) == 0)
            sentence[$urandom_range(0, 5)] = 8'($urandom_range(32, 126));
        add_sep();
        case ($urandom_range(0, 9))
            0:       add_junk();
            1, 2, 3: add_digits(6);
            default:
            begin
                add_digits(6);
                append_char(CH_DOT);
                add_digits(3);
            end
        endcase
        add_sep();
        if ($urandom_range(0, 11) == 0) add_junk(); else add_digits(2);
        add_sep();
        if ($urandom_range(0, 11) == 0) add_junk(); else add_digits(2);
        add_sep();
        if ($urandom_range(0, 11) == 0) add_junk(); else add_digits(4);
        add_sep();
        add_digits($urandom_range(1, 2));
        add_sep();
        add_digits($urandom_range(1, 2));
        append_char(CH_STAR);
        repeat (2)
            append_char(HEX_SET[$urandom_range(0, 15) * 8 +: 8]);
        // cut the sentence short now and then
        if (kind >= 90)
        begin
            n = $urandom_range(0, sentence.size() - 1);
            while (sentence.size() > n)
                void'(sentence.pop_back());
        end
    endtask

    initial
    begin : stimulus
        int first_word;
        int first_eom;
        clear_sentence();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < NDIR; r++)
        begin
            sentence.delete();
            load_text(dir_text[r]);
            send_sentence(dir_typed[r], dir_want[r]);
        end
        first_word = words_sent;
        first_eom  = eoms_sent;
        hold_due   = 1'b1;
        while (words_sent - first_word < RAND_WORDS || eoms_sent - first_eom < RAND_RESULTS)
        begin
            build_sentence();
            send_sentence(1'b0, NO_WANT);
        end
        item_valid <= 1'b0;
        while (zda_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && zda_due.size() == 0)
            $display("nmea_zda_time_parser_tb OK");
        else
            $display("nmea_zda_time_parser_tb NOT OK");
        $finish;
    end

    // Result side: random stalls, one long hold-off so that the input backs up
    initial
    begin : result_sink
        int span;
        int r;
        @(posedge rst_n);
        forever
        begin
            if (hold_due)
            begin
                hold_due = 1'b0;
                result_ready <= 1'b0;
                span = LONG_HOLD;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    span = $urandom_range(50, 200);
                else
                    span = $urandom_range(1, 8);
            end
            else
            begin
                result_ready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 75)
                    span = $urandom_range(1, 3);
                else if (r < 95)
                    span = $urandom_range(4, 12);
                else
                    span = $urandom_range(20, 60);
            end
            repeat (span) @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [13:0] want_v,
                               input logic [13:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && result_valid === 1'b1 && result_ready)
        begin
            if (zda_due.size() == 0)
            begin
                $error("result word with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = zda_due.pop_front();
                check_field("status",       14'(want.status),       14'(result.status));
                check_field("date_valid",   14'(want.date_valid),   14'(result.date_valid));
                check_field("time_valid",   14'(want.time_valid),   14'(result.time_valid));
                check_field("hours",        14'(want.hours),        14'(result.hours));
                check_field("minutes",      14'(want.minutes),      14'(result.minutes));
                check_field("seconds",      14'(want.seconds),      14'(result.seconds));
                check_field("milliseconds", 14'(want.milliseconds), 14'(result.milliseconds));
                check_field("day",          14'(want.day),          14'(result.day));
                check_field("month",        14'(want.month),        14'(result.month));
                check_field("year",         want.year,              result.year);
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("nmea_zda_time_parser_tb NOT OK");
        $finish;
    end

endmodule

[nmea_zda_time_parser.f]
hdl/nzda_pkg.sv
hdl/nzda_in_stage.sv
hdl/nzda_parse_core.sv
hdl/nzda_out_stage.sv
hdl/nmea_zda_time_parser.sv
tb/nmea_zda_time_parser_tb.sv
